@@ src/msk_pkg.sv @@
package msk_pkg;

    localparam int VAL_W          = 48;
    localparam int ACC_W          = 52;
    localparam int IO_W           = 32;
    localparam int NOISE_W        = 31;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int STATE_COUNT_DEF = 4;
    localparam int FRAC_BITS_DEF  = 32;

    localparam logic signed [VAL_W-1:0] SMAX = 48'sh7FFF_FFFF_FFFF;

    localparam logic [NOISE_W-1:0] PROC_NOISE_RST = 31'd65536;
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 31'd19660800;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 8'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            return SMAX;
        end
        if (v < -64'sh0000_7FFF_FFFF_FFFF) begin
            return -SMAX;
        end
        return v[VAL_W-1:0];
    endfunction

    // model matrix scaled by 2^32
    function automatic logic signed [63:0] a_raw(input int i, input int j);
        case (i * 8 + j)
            0:       return 64'sd4294967296;
            1:       return 64'sd4285476;
            2:       return -64'sd290941;
            3:       return 64'sd96378;
            9:       return 64'sd4271147819;
            10:      return -64'sd581337510;
            11:      return 64'sd176299667;
            18:      return 64'sd4294967296;
            25:      return -64'sd544670144;
            26:      return 64'sd40391564;
            27:      return 64'sd2451008476;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic logic signed [63:0] b_raw(input int i);
        case (i)
            0:       return 64'sd14070;
            1:       return 64'sd40391564;
            3:       return 64'sd1379009472;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] scale32(input logic signed [63:0] c,
                                                       input int fb);
        if (fb >= 32) begin
            return sat48(c <<< (fb - 32));
        end
        return sat48((c + (64'sd1 <<< (31 - fb))) >>> (32 - fb));
    endfunction

    function automatic logic signed [VAL_W-1:0] coef_a(input int i, input int j, input int fb);
        return scale32(a_raw(i, j), fb);
    endfunction

    function automatic logic signed [VAL_W-1:0] coef_b(input int i, input int fb);
        return scale32(b_raw(i), fb);
    endfunction

    // q16.16 to working format
    function automatic logic signed [VAL_W-1:0] cvt16(input logic signed [63:0] v,
                                                     input int fb);
        return sat48(v <<< (fb - 16));
    endfunction

endpackage

@@ src/msk_mul.sv @@
module msk_mul #(
    parameter int FRAC_BITS = msk_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [msk_pkg::VAL_W-1:0]  i_a,
    input  logic signed [msk_pkg::VAL_W-1:0]  i_b,
    output msk_pkg::t_unit_sts                o_sts,
    output logic signed [msk_pkg::VAL_W-1:0]  o_res
);

    localparam int VW = msk_pkg::VAL_W;
    localparam int HW = VW / 2;
    localparam int PW = 2 * VW + 1;

    logic            r_busy;
    logic            r_done;
    logic [2:0]      r_step;
    logic            r_neg;
    logic [VW-1:0]   r_ma;
    logic [VW-1:0]   r_mb;
    logic [PW-1:0]   r_acc;
    logic signed [VW-1:0] r_res;

    logic [HW-1:0]   pa;
    logic [HW-1:0]   pb;
    logic [VW-1:0]   prod;
    logic [PW-1:0]   shifted;
    logic [PW-1:0]   rnd;
    logic [PW-1:0]   qv;
    logic [VW-1:0]   mag;

    always_comb begin
        pa   = r_step[0] ? r_ma[VW-1:HW] : r_ma[HW-1:0];
        pb   = r_step[1] ? r_mb[VW-1:HW] : r_mb[HW-1:0];
        prod = pa * pb;
        case (r_step[1:0])
            2'd0:    shifted = PW'(prod);
            2'd3:    shifted = PW'(prod) << (2 * HW);
            default: shifted = PW'(prod) << HW;
        endcase
        rnd = r_acc + (PW'(1) << (FRAC_BITS - 1));
        qv  = rnd >> FRAC_BITS;
        mag = (qv > PW'(msk_pkg::SMAX)) ? VW'(msk_pkg::SMAX) : qv[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_acc  <= '0;
                r_neg  <= i_a[VW-1] ^ i_b[VW-1];
                r_ma   <= i_a[VW-1] ? VW'(-i_a) : VW'(i_a);
                r_mb   <= i_b[VW-1] ? VW'(-i_b) : VW'(i_b);
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_res  <= r_neg ? -$signed(mag) : $signed(mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc  <= r_acc + shifted;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_res;

endmodule

@@ src/msk_div.sv @@
module msk_div #(
    parameter int FRAC_BITS = msk_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [msk_pkg::VAL_W-1:0]  i_num,
    input  logic signed [msk_pkg::VAL_W-1:0]  i_den,
    output msk_pkg::t_unit_sts                o_sts,
    output logic signed [msk_pkg::VAL_W-1:0]  o_quo
);

    localparam int VW = msk_pkg::VAL_W;
    localparam int NW = VW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [NW-1:0]   r_num;
    logic [NW-1:0]   r_quo;
    logic [VW:0]     r_rem;
    logic [VW-1:0]   r_den;
    logic signed [VW-1:0] r_res;

    logic [VW:0]     trial;
    logic            fits;
    logic [VW-1:0]   mag;
    logic [VW-1:0]   num_mag;

    always_comb begin
        num_mag = i_num[VW-1] ? VW'(-i_num) : VW'(i_num);
        trial   = {r_rem[VW-1:0], r_num[NW-1]};
        fits    = trial >= {1'b0, r_den};
        mag     = (r_quo > NW'(msk_pkg::SMAX)) ? VW'(msk_pkg::SMAX) : r_quo[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_neg  <= i_num[VW-1];
                r_num  <= NW'(num_mag) << FRAC_BITS;
                r_quo  <= '0;
                r_rem  <= '0;
                r_den  <= VW'(i_den);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_res  <= r_neg ? -$signed(mag) : $signed(mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                    r_quo <= {r_quo[NW-2:0], fits};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_res;

endmodule

@@ src/motor_speed_kalman_filter_unit.sv @@
// one kalman predict and correct step per request on the motor model, giving the
// filtered speed state. a single 48x48 fixed-point multiplier (24x24 partial
// products) and a bit-serial divider are shared under a sequencer; with the
// default four states one step takes the 168 products and up to four gain
// divisions (skipped when the denominator is not positive). the input stalls
// while a step is running, the result waits in an output register. the user must
// see that noise registers are written only while idle; the block does not enforce it.
module motor_speed_kalman_filter_unit #(
    parameter int STATE_COUNT = msk_pkg::STATE_COUNT_DEF,
    parameter int FRAC_BITS   = msk_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [msk_pkg::IO_W-1:0]      i_drive_voltage,
    input  logic signed [msk_pkg::IO_W-1:0]      i_measured_speed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [msk_pkg::IO_W-1:0]      o_speed_estimate,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [msk_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [msk_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int N   = STATE_COUNT;
    localparam int IW  = $clog2(N);
    localparam int KW  = $clog2(N + 1);
    localparam int VW  = msk_pkg::VAL_W;
    localparam int AW  = msk_pkg::ACC_W;
    localparam int OSH = FRAC_BITS - 16;

    typedef enum logic [4:0] {
        ST_IDLE, ST_X_ISS, ST_X_WAIT, ST_TM_ISS, ST_TM_WAIT, ST_PP_ISS, ST_PP_WAIT,
        ST_Q, ST_D, ST_G_ISS, ST_G_WAIT, ST_E, ST_XU_ISS, ST_XU_WAIT,
        ST_PU_ISS, ST_PU_WAIT, ST_OUT
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [KW-1:0] r_k;
    logic signed [AW-1:0] r_acc;
    logic signed [VW-1:0] r_u;
    logic signed [VW-1:0] r_y;
    logic signed [VW-1:0] r_d;
    logic signed [VW-1:0] r_e;
    logic [msk_pkg::NOISE_W-1:0] r_proc_noise;
    logic [msk_pkg::NOISE_W-1:0] r_meas_noise;
    logic signed [VW-1:0] r_x    [N];
    logic signed [VW-1:0] r_xp   [N];
    logic signed [VW-1:0] r_gain [N];
    logic signed [VW-1:0] r_p    [N][N];
    logic signed [VW-1:0] r_tm   [N][N];
    logic signed [VW-1:0] r_pp   [N][N];
    logic                 r_out_valid;
    logic signed [msk_pkg::IO_W-1:0] r_out;

    logic                 mul_start;
    logic signed [VW-1:0] mul_a;
    logic signed [VW-1:0] mul_b;
    msk_pkg::t_unit_sts   mul_sts;
    logic signed [VW-1:0] mul_res;
    logic                 div_start;
    msk_pkg::t_unit_sts   div_sts;
    logic signed [VW-1:0] div_quo;

    logic signed [AW-1:0] acc_sum;
    logic signed [VW-1:0] acc_sat;
    logic                 i_last;
    logic                 j_last;
    logic                 k_last;
    logic signed [63:0]   out_rnd;
    logic signed [msk_pkg::IO_W-1:0] out_val;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        case (r_state)
            ST_X_ISS: begin
                mul_start = 1'b1;
                if (r_k == KW'(N)) begin
                    mul_a = msk_pkg::coef_b(int'(r_i), FRAC_BITS);
                    mul_b = r_u;
                end else begin
                    mul_a = msk_pkg::coef_a(int'(r_i), int'(r_k), FRAC_BITS);
                    mul_b = r_x[r_k[IW-1:0]];
                end
            end
            ST_TM_ISS: begin
                mul_start = 1'b1;
                mul_a     = msk_pkg::coef_a(int'(r_i), int'(r_k), FRAC_BITS);
                mul_b     = r_p[r_k[IW-1:0]][r_j];
            end
            ST_PP_ISS: begin
                mul_start = 1'b1;
                mul_a     = r_tm[r_i][r_k[IW-1:0]];
                mul_b     = msk_pkg::coef_a(int'(r_j), int'(r_k), FRAC_BITS);
            end
            ST_XU_ISS: begin
                mul_start = 1'b1;
                mul_a     = r_gain[r_i];
                mul_b     = r_e;
            end
            ST_PU_ISS: begin
                mul_start = 1'b1;
                mul_a     = r_gain[r_i];
                mul_b     = r_pp[IW'(1)][r_j];
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
        div_start = (r_state == ST_G_ISS) && (r_d > 0);
        acc_sum   = r_acc + AW'(mul_res);
        acc_sat   = msk_pkg::sat48(64'(acc_sum));
        i_last    = r_i == IW'(N - 1);
        j_last    = r_j == IW'(N - 1);
        k_last    = r_k == KW'(N - 1);
        out_rnd   = (64'(r_x[IW'(1)]) + (64'sd1 <<< (OSH - 1))) >>> OSH;
        if (out_rnd > 64'sd2147483647) begin
            out_val = 32'sh7FFF_FFFF;
        end else if (out_rnd < -64'sd2147483648) begin
            out_val = 32'sh8000_0000;
        end else begin
            out_val = out_rnd[msk_pkg::IO_W-1:0];
        end
    end

    msk_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts),
        .o_res   (mul_res)
    );

    msk_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pp[r_i][IW'(1)]),
        .i_den   (r_d),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_proc_noise <= msk_pkg::PROC_NOISE_RST;
            r_meas_noise <= msk_pkg::MEAS_NOISE_RST;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            for (int a = 0; a < N; a++) begin
                r_x[a] <= '0;
                for (int b = 0; b < N; b++) begin
                    r_p[a][b] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    msk_pkg::CFG_PROC_NOISE: r_proc_noise <= i_cfg_data[msk_pkg::NOISE_W-1:0];
                    msk_pkg::CFG_MEAS_NOISE: r_meas_noise <= i_cfg_data[msk_pkg::NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_u     <= msk_pkg::cvt16(64'(i_drive_voltage), FRAC_BITS);
                        r_y     <= msk_pkg::cvt16(64'(i_measured_speed), FRAC_BITS);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= ST_X_ISS;
                    end
                end
                ST_X_ISS:  r_state <= ST_X_WAIT;
                ST_X_WAIT: begin
                    if (mul_sts.done) begin
                        if (r_k == KW'(N)) begin
                            r_xp[r_i] <= acc_sat;
                            r_acc     <= '0;
                            r_k       <= '0;
                            r_i       <= i_last ? '0 : r_i + IW'(1);
                            r_state   <= i_last ? ST_TM_ISS : ST_X_ISS;
                        end else begin
                            r_acc   <= acc_sum;
                            r_k     <= r_k + KW'(1);
                            r_state <= ST_X_ISS;
                        end
                    end
                end
                ST_TM_ISS:  r_state <= ST_TM_WAIT;
                ST_TM_WAIT: begin
                    if (mul_sts.done) begin
                        r_state <= ST_TM_ISS;
                        if (k_last) begin
                            r_tm[r_i][r_j] <= acc_sat;
                            r_acc <= '0;
                            r_k   <= '0;
                            r_j   <= j_last ? '0 : r_j + IW'(1);
                            if (j_last) begin
                                r_i <= i_last ? '0 : r_i + IW'(1);
                                if (i_last) begin
                                    r_state <= ST_PP_ISS;
                                end
                            end
                        end else begin
                            r_acc <= acc_sum;
                            r_k   <= r_k + KW'(1);
                        end
                    end
                end
                ST_PP_ISS:  r_state <= ST_PP_WAIT;
                ST_PP_WAIT: begin
                    if (mul_sts.done) begin
                        r_state <= ST_PP_ISS;
                        if (k_last) begin
                            r_pp[r_i][r_j] <= acc_sat;
                            r_acc <= '0;
                            r_k   <= '0;
                            r_j   <= j_last ? '0 : r_j + IW'(1);
                            if (j_last) begin
                                r_i <= i_last ? '0 : r_i + IW'(1);
                                if (i_last) begin
                                    r_state <= ST_Q;
                                end
                            end
                        end else begin
                            r_acc <= acc_sum;
                            r_k   <= r_k + KW'(1);
                        end
                    end
                end
                ST_Q: begin
                    r_pp[IW'(1)][IW'(1)] <= msk_pkg::sat48(64'(r_pp[IW'(1)][IW'(1)])
                        + 64'(msk_pkg::cvt16(64'(r_proc_noise), FRAC_BITS)));
                    r_state <= ST_D;
                end
                ST_D: begin
                    r_d <= msk_pkg::sat48(64'(r_pp[IW'(1)][IW'(1)])
                        + 64'(msk_pkg::cvt16(64'(r_meas_noise), FRAC_BITS)));
                    r_i     <= '0;
                    r_state <= ST_G_ISS;
                end
                ST_G_ISS: begin
                    if (r_d > 0) begin
                        r_state <= ST_G_WAIT;
                    end else begin
                        r_gain[r_i] <= '0;
                        r_i     <= i_last ? '0 : r_i + IW'(1);
                        r_state <= i_last ? ST_E : ST_G_ISS;
                    end
                end
                ST_G_WAIT: begin
                    if (div_sts.done) begin
                        r_gain[r_i] <= div_quo;
                        r_i     <= i_last ? '0 : r_i + IW'(1);
                        r_state <= i_last ? ST_E : ST_G_ISS;
                    end
                end
                ST_E: begin
                    r_e     <= msk_pkg::sat48(64'(r_y) - 64'(r_xp[IW'(1)]));
                    r_i     <= '0;
                    r_state <= ST_XU_ISS;
                end
                ST_XU_ISS:  r_state <= ST_XU_WAIT;
                ST_XU_WAIT: begin
                    if (mul_sts.done) begin
                        r_x[r_i] <= msk_pkg::sat48(64'(r_xp[r_i]) + 64'(mul_res));
                        r_i     <= i_last ? '0 : r_i + IW'(1);
                        r_j     <= '0;
                        r_state <= i_last ? ST_PU_ISS : ST_XU_ISS;
                    end
                end
                ST_PU_ISS:  r_state <= ST_PU_WAIT;
                ST_PU_WAIT: begin
                    if (mul_sts.done) begin
                        r_p[r_i][r_j] <= msk_pkg::sat48(64'(r_pp[r_i][r_j]) - 64'(mul_res));
                        r_state <= ST_PU_ISS;
                        r_j     <= j_last ? '0 : r_j + IW'(1);
                        if (j_last) begin
                            r_i <= i_last ? '0 : r_i + IW'(1);
                            if (i_last) begin
                                r_state <= ST_OUT;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= out_val;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall       = r_state != ST_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_speed_estimate = r_out;
    assign o_cfg_ready      = 1'b1;

`ifndef SYNTHESIS
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier started while busy");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider both busy");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_X_ISS))
        else $error("accepted request did not start a step");
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside output state");
`endif

endmodule

@@ tb/motor_speed_kalman_filter_unit_tb.sv @@
module motor_speed_kalman_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 117;

    class speed_estimate_board;
        longint est_state[4];
        longint est_cov[4][4];
        longint proc_var;
        longint meas_var;
        logic [31:0] speed_queue[$];
        int errors;
        int checked;

        function new();
            int i;
            int j;
            for (i = 0; i < 4; i++) begin
                est_state[i] = 0;
                for (j = 0; j < 4; j++) est_cov[i][j] = 0;
            end
            proc_var = 65536;
            meas_var = 19660800;
            errors = 0;
            checked = 0;
        endfunction

        function longint model_a(int i, int j);
            case (i * 4 + j)
                0:       return 64'sd4294967296;
                1:       return 64'sd4285476;
                2:       return -64'sd290941;
                3:       return 64'sd96378;
                5:       return 64'sd4271147819;
                6:       return -64'sd581337510;
                7:       return 64'sd176299667;
                10:      return 64'sd4294967296;
                13:      return -64'sd544670144;
                14:      return 64'sd40391564;
                15:      return 64'sd2451008476;
                default: return 64'sd0;
            endcase
        endfunction

        function longint model_b(int i);
            case (i)
                0:       return 64'sd14070;
                1:       return 64'sd40391564;
                3:       return 64'sd1379009472;
                default: return 64'sd0;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > SAT_MAX) return SAT_MAX;
            if (v < -SAT_MAX) return -SAT_MAX;
            return v;
        endfunction

        function longint fmul(longint a, longint b);
            bit neg;
            logic [63:0] ua;
            logic [63:0] ub;
            logic [127:0] p;
            longint mag;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = {64'd0, ua} * {64'd0, ub};
            p = p + (128'd1 << 31);
            p = p >> 32;
            if (p > 128'(SAT_MAX)) mag = SAT_MAX;
            else mag = p[63:0];
            return neg ? -mag : mag;
        endfunction

        function longint fdiv(longint n, longint d);
            bit neg;
            logic [63:0] un;
            logic [127:0] t;
            longint mag;
            neg = n < 0;
            un = (n < 0) ? -n : n;
            if (un / d > (SAT_MAX >>> 32)) begin
                mag = SAT_MAX;
            end else begin
                t = ({64'd0, un} << 32) / {64'd0, d};
                mag = (t > 128'(SAT_MAX)) ? SAT_MAX : t[63:0];
            end
            return neg ? -mag : mag;
        endfunction

        function void set_reg(logic [7:0] idx, logic [31:0] data);
            if (idx == msk_pkg::CFG_PROC_NOISE) proc_var = data[30:0];
            else if (idx == msk_pkg::CFG_MEAS_NOISE) meas_var = data[30:0];
        endfunction

        function void note_request(logic [31:0] dv, logic [31:0] ms);
            longint u;
            longint y;
            longint qn;
            longint rn;
            longint acc;
            longint den;
            longint innov;
            longint o;
            longint xp[4];
            longint kg[4];
            longint tm[4][4];
            longint pp[4][4];
            int i;
            int j;
            int k;
            u = clamp(longint'(signed'(dv)) <<< 16);
            y = clamp(longint'(signed'(ms)) <<< 16);
            qn = clamp(proc_var <<< 16);
            rn = clamp(meas_var <<< 16);
            for (i = 0; i < 4; i++) begin
                acc = fmul(model_b(i), u);
                for (j = 0; j < 4; j++) acc += fmul(model_a(i, j), est_state[j]);
                xp[i] = clamp(acc);
            end
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    acc = 0;
                    for (k = 0; k < 4; k++) acc += fmul(model_a(i, k), est_cov[k][j]);
                    tm[i][j] = clamp(acc);
                end
            end
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    acc = 0;
                    for (k = 0; k < 4; k++) acc += fmul(tm[i][k], model_a(j, k));
                    pp[i][j] = clamp(acc);
                end
            end
            pp[1][1] = clamp(pp[1][1] + qn);
            den = clamp(pp[1][1] + rn);
            for (i = 0; i < 4; i++) kg[i] = (den > 0) ? fdiv(pp[i][1], den) : 0;
            innov = clamp(y - xp[1]);
            for (i = 0; i < 4; i++) est_state[i] = clamp(xp[i] + fmul(kg[i], innov));
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    est_cov[i][j] = clamp(pp[i][j] - fmul(kg[i], pp[1][j]));
                end
            end
            o = (est_state[1] + 64'sd32768) >>> 16;
            if (o > 64'sd2147483647) o = 64'sd2147483647;
            if (o < -64'sd2147483648) o = -64'sd2147483648;
            speed_queue.push_back(o[31:0]);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch: %s got %h want %h (result %0d)", what, got, want, checked);
        endtask

        task check_speed(logic [31:0] got);
            logic [31:0] want;
            if (speed_queue.size() == 0) begin
                report("unexpected speed_estimate", got, 32'h0);
            end else begin
                want = speed_queue.pop_front();
                if (got !== want) report("speed_estimate", got, want);
            end
            checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_drive_voltage = '0;
    logic signed [31:0] i_measured_speed = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_speed_estimate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    speed_estimate_board board = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int cfg_writes = 0;

    motor_speed_kalman_filter_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_drive_voltage(i_drive_voltage), .i_measured_speed(i_measured_speed),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_speed_estimate(o_speed_estimate),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #100ms;
        $display("[motor_speed_kalman_filter_unit] ERROR");
        $finish;
    end

    // result side: random stall, one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) board.check_speed(o_speed_estimate);
            if (hold_req && hold_left == 0) begin
                hold_req = 1'b0;
                hold_left = 4000;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 9) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                             : $urandom_range(1, 5);
                end
            end
        end
    end

    task write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task send_request(logic [31:0] dv, logic [31:0] ms);
        int gap;
        i_in_valid <= 1'b1;
        i_drive_voltage <= dv;
        i_measured_speed <= ms;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(dv, ms);
        if (calm) gap = 0;
        else if ($urandom_range(0, 9) < 7) gap = $urandom_range(0, 3);
        else if ($urandom_range(0, 4) != 0) gap = $urandom_range(4, 20);
        else gap = $urandom_range(50, 300);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task drain;
        i_in_valid <= 1'b0;
        while (board.speed_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function logic [31:0] pick_word(logic [31:0] center);
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 131072) - 65536;
            default: return center + $urandom_range(0, 2621440) - 1310720;
        endcase
    endfunction

    initial begin
        logic [31:0] volts;
        logic [31:0] speed;
        logic [30:0] qv;
        logic [30:0] rv;
        int p;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero noise: denominator zero, gains zero
        write_reg(msk_pkg::CFG_PROC_NOISE, 32'd0);
        write_reg(msk_pkg::CFG_MEAS_NOISE, 32'd0);
        send_request(32'h0001_0000, 32'h0005_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        // out-of-range index ignored, bit 31 of data ignored
        write_reg(8'd2, 32'h1234_5678);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(msk_pkg::CFG_PROC_NOISE, 32'hFFFF_FFFF);
        write_reg(msk_pkg::CFG_MEAS_NOISE, 32'h8000_0001);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h0, 32'h0);
        send_request(32'hFFFF_FFFF, 32'h0000_0001);
        drain();
        write_reg(msk_pkg::CFG_PROC_NOISE, 32'h7FFF_FFFF);
        write_reg(msk_pkg::CFG_MEAS_NOISE, 32'h7FFF_FFFF);
        send_request(32'h0064_0000, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h0);
        drain();
        write_reg(msk_pkg::CFG_PROC_NOISE, 32'd65536);
        write_reg(msk_pkg::CFG_MEAS_NOISE, 32'd19660800);
        for (n = 0; n < 12; n++) begin
            send_request(32'h000C_0000, 32'h0000_0000 + n * 32'h0004_0000);
        end
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin qv = 31'd65536; rv = 31'd19660800; end
                1: begin qv = 31'd0; rv = 31'd1; end
                2: begin qv = 31'h7FFF_FFFF; rv = 31'h7FFF_FFFF; end
                3: begin qv = 31'd655360; rv = 31'd65536; end
                4: begin qv = 31'd1; rv = 31'h7FFF_FFFF; end
                default: begin qv = 31'($urandom); rv = 31'($urandom); end
            endcase
            write_reg(msk_pkg::CFG_PROC_NOISE, {1'b0, qv});
            write_reg(msk_pkg::CFG_MEAS_NOISE, {1'b0, rv});
            calm = (p == 5);
            if (p == 3) hold_req = 1'b1;
            volts = $urandom_range(0, 1572864);
            speed = 32'd0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0) volts = pick_word(volts);
                speed = (speed + volts) / 2;
                if ($urandom_range(0, 9) < 8) send_request(volts, speed + $urandom_range(0, 65535));
                else send_request(pick_word(volts), pick_word(speed));
            end
            drain();
        end
        calm = 1'b0;

        $display("covered %0d speed results over %0d register writes and %0d random phases",
                 board.checked, cfg_writes, PHASES);
        $display("noise settings spanned zero, one and full scale with long output holds");
        if (board.errors == 0 && board.speed_queue.size() == 0) begin
            $display("[motor_speed_kalman_filter_unit] OK");
        end else begin
            $display("[motor_speed_kalman_filter_unit] ERROR");
        end
        $finish;
    end
endmodule
